### rtl/core/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, sizes and codes of the LRU signature cache.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int ENTRIES    = 8;
   localparam int CODE_BYTES = 8;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int STAMP_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 3;

   localparam logic [63:0] CODE_MASK =
      (CODE_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * CODE_BYTES)) - 64'd1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MISS     = 2'd0,
      STATUS_HIT      = 2'd1,
      STATUS_INSERTED = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0]      cs_ip;
      logic [63:0]      code;
      logic [63:0]      size_writes;
      logic [3:0][63:0] regs;
   } key_type;

   typedef struct packed {
      logic key_eq;
      logic stamp_valid;
      logic stamp_less;
   } match_type;

endpackage

### rtl/core/lsc_key_store.sv
// ----------------------------------------------------------------------------
// lsc_key_store
// Key memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lsc_key_store import lsc_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  key_type          wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output key_type          rd_data
);

   key_type mem [ENTRIES];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lsc_match_unit.sv
// ----------------------------------------------------------------------------
// lsc_match_unit
// Shared compare unit: key equality, stamp valid and stamp age compare.
// ----------------------------------------------------------------------------
module lsc_match_unit import lsc_pkg::*; (
   input  key_type            probe_key,
   input  key_type            entry_key,
   input  logic [STAMP_W-1:0] entry_stamp,
   input  logic [STAMP_W-1:0] oldest_stamp,
   output match_type          result
);

   assign result.key_eq      = (probe_key == entry_key);
   assign result.stamp_valid = (entry_stamp != '0);
   assign result.stamp_less  = (entry_stamp < oldest_stamp);

endmodule

### rtl/core/lru_signature_cache_top.sv
// ----------------------------------------------------------------------------
// lru_signature_cache_top
// Fully associative cache of processor state keys, LRU replacement by stamps.
// ----------------------------------------------------------------------------
// A lookup hit ends the scan early. One entry is checked per cycle by the shared
// compare unit behind the key memory read port. Next request may start the
// cycle the response is shown. Reset clears all stamps (all entries invalid)
// and sets the stamp counter to one; the key memory is not cleared.
// ----------------------------------------------------------------------------
module lru_signature_cache_top import lsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [31:0]         req_cs_ip,
   input  logic [63:0]         req_code_bytes,
   input  logic [31:0]         req_image_size,
   input  logic [31:0]         req_write_count,
   input  logic [63:0]         req_reg_ax_bx,
   input  logic [63:0]         req_reg_cx_dx,
   input  logic [63:0]         req_reg_si_di,
   input  logic [63:0]         req_reg_bp_sp,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic               func_ff, func_in;
   key_type            key_ff, key_in;
   logic [IDX_W-1:0]   issue_idx_ff, issue_idx_in;
   logic               issue_live_ff, issue_live_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [STAMP_W-1:0] oldest_ff, oldest_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic               hit_ff, hit_in;
   logic [STAMP_W-1:0] next_stamp_ff, next_stamp_in;
   logic [STAMP_W-1:0] stamp_ff [ENTRIES];
   logic [STAMP_W-1:0] stamp_in [ENTRIES];
   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   logic               key_wr;
   key_type            entry_key;
   logic [STAMP_W-1:0] chk_stamp;
   match_type          mres;

   lsc_key_store u_key_store (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (victim_ff),
      .wr_data (key_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (entry_key)
   );

   assign chk_stamp = stamp_ff[chk_idx_ff];

   lsc_match_unit u_match (
      .probe_key    (key_ff),
      .entry_key    (entry_key),
      .entry_stamp  (chk_stamp),
      .oldest_stamp (oldest_ff),
      .result       (mres)
   );

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      issue_idx_in  = issue_idx_ff;
      issue_live_in = issue_live_ff;
      chk_idx_in    = issue_idx_ff;
      chk_vld_in    = 1'b0;
      oldest_in     = oldest_ff;
      victim_in     = victim_ff;
      hit_in        = hit_ff;
      next_stamp_in = next_stamp_ff;
      stamp_in      = stamp_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      key_wr        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in             = req_func;
               key_in.cs_ip        = req_cs_ip;
               key_in.code         = req_code_bytes & CODE_MASK;
               key_in.size_writes  = {req_image_size, req_write_count};
               key_in.regs[0]      = req_reg_ax_bx;
               key_in.regs[1]      = req_reg_cx_dx;
               key_in.regs[2]      = req_reg_si_di;
               key_in.regs[3]      = req_reg_bp_sp;
               issue_idx_in        = '0;
               issue_live_in       = 1'b1;
               oldest_in           = next_stamp_ff;
               victim_in           = '0;
               hit_in              = 1'b0;
               state_in            = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_vld_in = issue_live_ff;
            if (issue_live_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issue_live_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            if (chk_vld_ff) begin
               if (func_ff == FUNC_LOOKUP) begin
                  if (mres.stamp_valid && mres.key_eq) begin
                     hit_in    = 1'b1;
                     victim_in = chk_idx_ff;
                     state_in  = ST_FINISH;
                  end else if (chk_idx_ff == LAST_IDX) begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  if (mres.stamp_less) begin
                     oldest_in = chk_stamp;
                     victim_in = chk_idx_ff;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (func_ff == FUNC_INSERT) begin
               key_wr              = 1'b1;
               stamp_in[victim_ff] = next_stamp_ff;
               next_stamp_in       = next_stamp_ff + 1'b1;
               rsp_status_in       = STATUS_INSERTED;
               rsp_slot_in         = SLOT_W'(victim_ff);
            end else if (hit_ff) begin
               stamp_in[victim_ff] = next_stamp_ff;
               next_stamp_in       = next_stamp_ff + 1'b1;
               rsp_status_in       = STATUS_HIT;
               rsp_slot_in         = SLOT_W'(victim_ff);
            end else begin
               rsp_status_in = STATUS_MISS;
               rsp_slot_in   = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      issue_idx_ff  <= issue_idx_in;
      chk_idx_ff    <= chk_idx_in;
      oldest_ff     <= oldest_in;
      victim_ff     <= victim_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_live_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         next_stamp_ff <= STAMP_W'(1);
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         issue_live_ff <= issue_live_in;
         chk_vld_ff    <= chk_vld_in;
         next_stamp_ff <= next_stamp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         stamp_ff      <= stamp_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule
